// ----- hw/rtl/srtq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W        = 8;
    localparam int PRI_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int ENTRY_W     = ID_W + PRI_W;

    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 24;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [ID_W-1:0]  id;
    } entry_t;

    function automatic ptr_t next_slot(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic ptr_t prev_slot(input ptr_t p);
        ptr_t r;
        if (p == '0) begin
            r = PTR_W'(QUEUE_DEPTH - 1);
        end else begin
            r = p - ptr_t'(1);
        end
        return r;
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input cnt_t c);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, c};
        return wide[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_ready_task_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                                 tuser
// s_        in   task_id[7:0], priority_req[15:8]                   cmd[0]
// m_        out  status[1:0], popped_id[9:2], popped_priority[17:10],
//                occupancy[22:18], zero fill[23]                    -
//
// One item at a time. Pop: the head slot is read, then S_POP and S_OUT load
// the output register. Push: the new task walks from the tail toward the head
// past each entry with a larger priority number, S_STEP reading the previous
// slot and S_CMP comparing and writing, in a read-compare-write walk over the slot memory.
// Full/empty rejects go straight to S_OUT. aresetn (synchronous) empties the queue.
// A stalled m_ side holds the result; one more item is taken and waits in
// S_OUT, and s_tready stays low until the held result drains.

module sorted_ready_task_queue
    import srtq_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [S_DATA_W-1:0]   s_tdata,   // task_id, priority_req
    input  wire [0:0]            s_tuser,   // cmd
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // status, popped_id, popped_priority, occupancy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CMP,
        S_POP,
        S_OUT
    } state_t;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t               state_reg;
    ptr_t                 head_reg;
    ptr_t                 tail_reg;
    ptr_t                 pos_reg;
    cnt_t                 cnt_reg;
    entry_t               new_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    entry_t               res_entry_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic                 s_accept;
    logic                 in_cmd;
    entry_t               in_entry;
    logic                 rd_en;
    ptr_t                 rd_addr;
    logic                 wr_en;
    ptr_t                 wr_addr;
    entry_t               wr_data;
    logic                 out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = s_tuser[0];
    assign in_entry = '{pri: s_tdata[15:8], id: s_tdata[7:0]};
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = new_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && in_cmd == CMD_POP && cnt_reg != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = head_reg;
                end
            end
            S_STEP: begin
                if (pos_reg == head_reg) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = prev_slot(pos_reg);
                end
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (new_reg.pri < rd_data_reg.pri) begin
                    wr_data = rd_data_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        new_reg       <= in_entry;
                        pos_reg       <= tail_reg;
                        res_status_reg <= ST_OK;
                        res_entry_reg <= '0;
                        if (in_cmd == CMD_PUSH) begin
                            if (cnt_reg == CNT_W'(QUEUE_DEPTH)) begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_OUT;
                            end else begin
                                state_reg <= S_STEP;
                            end
                        end else begin
                            if (cnt_reg == '0) begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_OUT;
                            end else begin
                                state_reg <= S_POP;
                            end
                        end
                    end
                end
                S_STEP: begin
                    if (pos_reg == head_reg) begin
                        tail_reg  <= next_slot(tail_reg);
                        cnt_reg   <= cnt_reg + cnt_t'(1);
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (new_reg.pri < rd_data_reg.pri) begin
                        pos_reg   <= prev_slot(pos_reg);
                        state_reg <= S_STEP;
                    end else begin
                        tail_reg  <= next_slot(tail_reg);
                        cnt_reg   <= cnt_reg + cnt_t'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_POP: begin
                    res_entry_reg <= rd_data_reg;
                    head_reg      <= next_slot(head_reg);
                    cnt_reg       <= cnt_reg - cnt_t'(1);
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, occ_of(cnt_reg), res_entry_reg.pri,
                                         res_entry_reg.id, res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == CNT_W'(QUEUE_DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with entry count");

    a_cmp_not_head: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |-> pos_reg != head_reg)
        else $error("compare step at head slot");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_cmd == CMD_PUSH && cnt_reg == CNT_W'(QUEUE_DEPTH))
        |=> (state_reg == S_OUT && res_status_reg == ST_FULL && $stable(cnt_reg)))
        else $error("push on full queue not rejected");

    a_empty_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_cmd == CMD_POP && cnt_reg == '0)
        |=> (state_reg == S_OUT && res_status_reg == ST_EMPTY && $stable(head_reg)))
        else $error("pop on empty queue not rejected");

endmodule

`default_nettype wire

// ----- verif/sorted_ready_task_queue_tb.sv -----
`timescale 1ns / 1ps

class ready_queue_tracker;

    typedef struct {
        logic [srtq_pkg::STATUS_W-1:0] status;
        logic [srtq_pkg::ID_W-1:0]     id;
        logic [srtq_pkg::PRI_W-1:0]    pri;
        logic [srtq_pkg::OCC_W-1:0]    occ;
    } outcome_t;

    logic [srtq_pkg::ID_W-1:0]  slot_id[srtq_pkg::QUEUE_DEPTH];
    logic [srtq_pkg::PRI_W-1:0] slot_pri[srtq_pkg::QUEUE_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned count;
    outcome_t    expected_outcomes[$];
    int          failures;

    function new();
        head     = 0;
        tail     = 0;
        count    = 0;
        failures = 0;
    endfunction

    function int pending();
        return expected_outcomes.size();
    endfunction

    function void note_request(logic cmd, logic [srtq_pkg::ID_W-1:0] id,
                               logic [srtq_pkg::PRI_W-1:0] pri);
        outcome_t                   res;
        int unsigned                pos;
        int unsigned                prv;
        logic [srtq_pkg::ID_W-1:0]  tid;
        logic [srtq_pkg::PRI_W-1:0] tpr;
        res.status = srtq_pkg::ST_OK;
        res.id     = '0;
        res.pri    = '0;
        if (cmd == srtq_pkg::CMD_PUSH) begin
            if (count >= srtq_pkg::QUEUE_DEPTH) begin
                res.status = srtq_pkg::ST_FULL;
            end else begin
                pos           = tail;
                slot_id[pos]  = id;
                slot_pri[pos] = pri;
                // move toward head past strictly larger priority numbers
                while (pos != head) begin
                    prv = (pos == 0) ? srtq_pkg::QUEUE_DEPTH - 1 : pos - 1;
                    if (slot_pri[pos] < slot_pri[prv]) begin
                        tid           = slot_id[pos];
                        tpr           = slot_pri[pos];
                        slot_id[pos]  = slot_id[prv];
                        slot_pri[pos] = slot_pri[prv];
                        slot_id[prv]  = tid;
                        slot_pri[prv] = tpr;
                        pos           = prv;
                    end else begin
                        break;
                    end
                end
                count++;
                tail = (tail + 1) % srtq_pkg::QUEUE_DEPTH;
            end
        end else begin
            if (count == 0) begin
                res.status = srtq_pkg::ST_EMPTY;
            end else begin
                res.id  = slot_id[head];
                res.pri = slot_pri[head];
                head    = (head + 1) % srtq_pkg::QUEUE_DEPTH;
                count--;
            end
        end
        res.occ = count[srtq_pkg::OCC_W-1:0];
        expected_outcomes.push_back(res);
    endfunction

    function void check_result(logic [srtq_pkg::M_DATA_W-1:0] data);
        outcome_t exp_res;
        if (expected_outcomes.size() == 0) begin
            $error("unexpected result item: tdata %h", data);
            failures++;
            return;
        end
        exp_res = expected_outcomes.pop_front();
        if (data[1:0] !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, data[1:0]);
            failures++;
        end
        if (data[9:2] !== exp_res.id) begin
            $error("popped_id: expected %0d, actual %0d", exp_res.id, data[9:2]);
            failures++;
        end
        if (data[17:10] !== exp_res.pri) begin
            $error("popped_priority: expected %0d, actual %0d", exp_res.pri, data[17:10]);
            failures++;
        end
        if (data[22:18] !== exp_res.occ) begin
            $error("occupancy: expected %0d, actual %0d", exp_res.occ, data[22:18]);
            failures++;
        end
    endfunction

endclass

module sorted_ready_task_queue_tb;
    import srtq_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_ITEM = 1250;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // task_id[7:0], priority_req[15:8]
    logic [0:0]          s_tuser;   // cmd[0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // status[1:0], popped_id[9:2], popped_priority[17:10],
                                    // occupancy[22:18], zero[23]

    ready_queue_tracker queue_model;
    int tx_idle_pct;
    int rx_idle_pct;
    int items_accepted;
    int cycle_count;

    sorted_ready_task_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [PRI_W-1:0] pri);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {pri, id};
        s_tuser[0] <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                queue_model.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                queue_model.note_request(s_tuser[0], s_tdata[7:0], s_tdata[15:8]);
                items_accepted++;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off while the sender keeps offering items
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("sorted_ready_task_queue: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int             n;
        int             seg_left;
        int             push_pct;
        int             pri_mode;
        logic           cmd;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        queue_model    = new();
        items_accepted = 0;
        tx_idle_pct    = 19;
        rx_idle_pct    = 55;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pop on empty, extremes, equal priorities, drain past empty
        send_item(CMD_POP,  8'hFF, 8'hFF);
        send_item(CMD_PUSH, 8'h00, 8'hFF);
        send_item(CMD_PUSH, 8'hFF, 8'h00);
        send_item(CMD_PUSH, 8'hA5, 8'h80);
        send_item(CMD_PUSH, 8'h5A, 8'h80);
        send_item(CMD_PUSH, 8'h3C, 8'h00);
        repeat (6) send_item(CMD_POP, 8'h00, 8'h00);

        // first segment is all pushes so the queue fills and rejects
        seg_left = 24;
        push_pct = 100;
        pri_mode = 1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 19;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(80, 20);
                case ($urandom_range(4))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    2: push_pct = 60;
                    3: push_pct = 80;
                    default: push_pct = 95;
                endcase
                pri_mode = $urandom_range(2);
            end
            seg_left--;
            cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            id  = ID_W'($urandom_range(255));
            case (pri_mode)
                0: pri = PRI_W'($urandom_range(255));
                1: pri = PRI_W'($urandom_range(3));
                default: pri = $urandom_range(1) ? 8'hFF : 8'h00;
            endcase
            send_item(cmd, id, pri);
        end
        s_tvalid <= 1'b0;

        while (queue_model.pending() != 0) @(posedge aclk);
        repeat (2 * QUEUE_DEPTH + 10) @(posedge aclk);
        if (queue_model.failures == 0) begin
            $display("sorted_ready_task_queue: match");
        end else begin
            $display("sorted_ready_task_queue: mismatch");
        end
        $finish;
    end

endmodule
